### sv/tcst_pkg.sv
// ----------------------------------------------------------------------------
// tcst_pkg
// Shared types and constants for the touch contact slot tracker.
// ----------------------------------------------------------------------------
package tcst_pkg;

  // Table geometry.
  localparam int SLOT_COUNT = 5;
  localparam int COORD_BITS = 16;
  localparam int ID_W       = 32;
  localparam int PHASE_W    = 3;
  localparam int RAD_W      = 15;

  // Slot index and active-count widths.
  localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_RAW = $clog2(SLOT_COUNT + 1);
  localparam int CNT_W   = (CNT_RAW > 3) ? CNT_RAW : 3;

  // The reported count saturates at seven.
  localparam int FULL_CNT = (SLOT_COUNT > 7) ? 7 : SLOT_COUNT;

  // Width that holds either a coordinate difference or the radius.
  localparam int CMP_W = (COORD_BITS + 1 > RAD_W) ? COORD_BITS + 1 : RAD_W + 1;
  localparam int SQ_W  = 2 * RAD_W;

  // Phase codes with special meaning.
  localparam logic [PHASE_W-1:0] PHASE_ENDED   = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_INVALID = 3'd5;

  // Item commands.
  typedef enum logic [1:0] {
    CMD_TOUCH     = 2'd0,
    CMD_FRAME     = 2'd1,
    CMD_HIT_ENDED = 2'd2,
    CMD_HIT_ANY   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                          cmd;
    logic [ID_W-1:0]               contact_id;
    logic [PHASE_W-1:0]            phase;
    logic signed [COORD_BITS-1:0]  x_pos;
    logic signed [COORD_BITS-1:0]  y_pos;
    logic [RAD_W-1:0]              radius;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] active_count;
    logic       dropped;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clr_idx;
    logic inc_idx;
    logic scan;
    logic commit;
    logic clear_ended;
    logic sq_r;
    logic diff;
    logic sq_x;
    logic sq_y;
    logic check;
    logic report;
  } dp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic slot_ok;
    logic slot_hit;
  } dp_sts_t;

endpackage

### sv/touch_contact_slot_tracker_core.sv
// ----------------------------------------------------------------------------
// touch_contact_slot_tracker_core
// Touch contact table with touch events, frame updates and radius hit tests.
// ----------------------------------------------------------------------------
//
//   channel   ports                     handshake
//   -------   -----------------------   ------------------------------------
//   input     start, busy, in_item      item taken when start && !busy
//   result    out_valid, out_item       one-cycle strobe, cannot be held off
//
// A touch event makes one id compare per slot. A hit test squares the radius
// once and then, for each slot inside the radius box, steps through the
// difference, the squares of dx and dy on the shared squaring multiplier and
// the check; a hit ends the scan early.
// The result strobe comes in the cycle in which busy falls.
// Reset is synchronous and active low; it empties the table.
// ----------------------------------------------------------------------------
module touch_contact_slot_tracker_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tcst_pkg::in_item_t  in_item,
  output logic                out_valid,
  output tcst_pkg::out_item_t out_item
);
  import tcst_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  // Sequencer.
  tcst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (in_item.cmd),
    .sts       (sts),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Slot table and arithmetic.
  tcst_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .ctl      (ctl),
    .sts      (sts),
    .out_item (out_item)
  );

`ifndef SYNTHESIS
  // An accepted item makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // Every item runs through at least one working state before ST_REPORT, so strobes never touch.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A dropped event means every slot was in use.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.dropped) |-> (out_item.active_count == 3'(FULL_CNT)))
    else $error("event dropped while a slot was free");

  // A result appears only as an item finishes.
  a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result strobe outside the end of an item");
`endif

endmodule

### sv/tcst_dp.sv
// ----------------------------------------------------------------------------
// tcst_dp
// Datapath: slot table, scan index, shared squaring multiplier and result
// register.
// ----------------------------------------------------------------------------
module tcst_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  tcst_pkg::in_item_t in_item,
  input  tcst_pkg::dp_ctl_t  ctl,
  output tcst_pkg::dp_sts_t  sts,
  output tcst_pkg::out_item_t out_item
);
  import tcst_pkg::*;

  // Slot table.
  logic [ID_W-1:0]              ident_r [SLOT_COUNT];
  logic [PHASE_W-1:0]           phase_r [SLOT_COUNT];
  logic signed [COORD_BITS-1:0] x_r     [SLOT_COUNT];
  logic signed [COORD_BITS-1:0] y_r     [SLOT_COUNT];

  // Working registers for one item.
  in_item_t         item_r;
  logic [IDX_W-1:0] idx_r;
  logic             match_found_r;
  logic [IDX_W-1:0] match_idx_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             hit_r;
  logic             dropped_r;
  logic [RAD_W-1:0] dx_r;
  logic [RAD_W-1:0] dy_r;
  logic [SQ_W-1:0]  r2_r;
  logic [SQ_W-1:0]  sqx_r;
  logic [SQ_W-1:0]  sqy_r;
  out_item_t        out_r;

  logic signed [CMP_W-1:0] dxs;
  logic signed [CMP_W-1:0] dys;
  logic [CMP_W-1:0]        dx_abs;
  logic [CMP_W-1:0]        dy_abs;
  logic                    qual;
  logic [RAD_W-1:0]        mul_a;
  logic [SQ_W-1:0]         prod;
  logic [SQ_W:0]           dist2;
  logic [IDX_W-1:0]        sel;
  logic [CNT_W-1:0]        cnt;

  // Item capture at accept.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_item;
    end
  end

  // Scan index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (ctl.clr_idx) begin
      idx_r <= '0;
    end else if (ctl.inc_idx) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  assign sts.last = (idx_r == IDX_W'(SLOT_COUNT - 1));

  // Distance terms of the slot under the index.
  assign dxs    = CMP_W'(x_r[idx_r]) - CMP_W'(item_r.x_pos);
  assign dys    = CMP_W'(y_r[idx_r]) - CMP_W'(item_r.y_pos);
  assign dx_abs = dxs[CMP_W-1] ? CMP_W'(-dxs) : CMP_W'(dxs);
  assign dy_abs = dys[CMP_W-1] ? CMP_W'(-dys) : CMP_W'(dys);
  assign qual   = (item_r.cmd == CMD_HIT_ENDED) ? (phase_r[idx_r] == PHASE_ENDED)
                                                : (phase_r[idx_r] != PHASE_INVALID);
  assign sts.slot_ok = qual && (dx_abs <= CMP_W'(item_r.radius))
                            && (dy_abs <= CMP_W'(item_r.radius));

  // Shared squaring multiplier.
  always_comb begin
    if (ctl.sq_r) begin
      mul_a = item_r.radius;
    end else if (ctl.sq_x) begin
      mul_a = dx_r;
    end else begin
      mul_a = dy_r;
    end
  end
  assign prod = mul_a * mul_a;

  always_ff @(posedge clk) begin
    if (ctl.diff) begin
      dx_r <= dx_abs[RAD_W-1:0];
      dy_r <= dy_abs[RAD_W-1:0];
    end
    if (ctl.sq_r) begin
      r2_r <= prod;
    end
    if (ctl.sq_x) begin
      sqx_r <= prod;
    end
    if (ctl.sq_y) begin
      sqy_r <= prod;
    end
  end

  // Squared distance against squared radius.
  assign dist2        = (SQ_W + 1)'(sqx_r) + (SQ_W + 1)'(sqy_r);
  assign sts.slot_hit = (dist2 <= (SQ_W + 1)'(r2_r));

  // Slot selection for a touch event: a matching id wins over a free slot.
  assign sel = match_found_r ? match_idx_r : free_idx_r;

  // Per-item flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      hit_r         <= 1'b0;
      dropped_r     <= 1'b0;
    end else if (ctl.load) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      hit_r         <= 1'b0;
      dropped_r     <= 1'b0;
    end else begin
      if (ctl.scan && !match_found_r && (ident_r[idx_r] == item_r.contact_id)) begin
        match_found_r <= 1'b1;
      end
      if (ctl.scan && !free_found_r && (phase_r[idx_r] == PHASE_INVALID)) begin
        free_found_r <= 1'b1;
      end
      if (ctl.commit && !match_found_r && !free_found_r) begin
        dropped_r <= 1'b1;
      end
      if (ctl.check && sts.slot_hit) begin
        hit_r <= 1'b1;
      end
    end
  end

  // First matching and first free index.
  always_ff @(posedge clk) begin
    if (ctl.scan && !match_found_r) begin
      match_idx_r <= idx_r;
    end
    if (ctl.scan && !free_found_r) begin
      free_idx_r <= idx_r;
    end
  end

  // Identifier and phase: written by touch events, freed by frame updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        ident_r[i] <= '0;
        phase_r[i] <= PHASE_INVALID;
      end
    end else if (ctl.commit && (match_found_r || free_found_r)) begin
      ident_r[sel] <= item_r.contact_id;
      phase_r[sel] <= item_r.phase;
    end else if (ctl.clear_ended) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (phase_r[i] == PHASE_ENDED) begin
          ident_r[i] <= '0;
          phase_r[i] <= PHASE_INVALID;
        end
      end
    end
  end

  // Positions carry no reset; they are read only for slots in use.
  always_ff @(posedge clk) begin
    if (ctl.commit && (match_found_r || free_found_r)) begin
      x_r[sel] <= item_r.x_pos;
      y_r[sel] <= item_r.y_pos;
    end
  end

  // Active slot count over the whole table.
  always_comb begin
    cnt = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      cnt = cnt + CNT_W'(phase_r[i] != PHASE_INVALID);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.report) begin
      out_r.hit          <= hit_r;
      out_r.dropped      <= dropped_r;
      out_r.active_count <= (cnt > CNT_W'(7)) ? 3'd7 : cnt[2:0];
    end
  end

  assign out_item = out_r;

endmodule

### sv/tcst_ctrl.sv
// ----------------------------------------------------------------------------
// tcst_ctrl
// Controller: sequences slot scans, the hit-test steps and the result strobe.
// ----------------------------------------------------------------------------
module tcst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  tcst_pkg::cmd_t    cmd,
  input  tcst_pkg::dp_sts_t sts,
  output tcst_pkg::dp_ctl_t ctl,
  output logic              busy,
  output logic              out_valid
);
  import tcst_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_SCAN   = 10'b00_0000_0010,
    ST_COMMIT = 10'b00_0000_0100,
    ST_CLEAR  = 10'b00_0000_1000,
    ST_RSQ    = 10'b00_0001_0000,
    ST_DIFF   = 10'b00_0010_0000,
    ST_SQX    = 10'b00_0100_0000,
    ST_SQY    = 10'b00_1000_0000,
    ST_CHECK  = 10'b01_0000_0000,
    ST_REPORT = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.load    = 1'b1;
          ctl.clr_idx = 1'b1;
          case (cmd)
            CMD_TOUCH: state_nxt = ST_SCAN;
            CMD_FRAME: state_nxt = ST_CLEAR;
            default:   state_nxt = ST_RSQ;
          endcase
        end
      end
      ST_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.last) begin
          state_nxt = ST_COMMIT;
        end else begin
          ctl.inc_idx = 1'b1;
        end
      end
      ST_COMMIT: begin
        ctl.commit = 1'b1;
        state_nxt  = ST_REPORT;
      end
      ST_CLEAR: begin
        ctl.clear_ended = 1'b1;
        state_nxt       = ST_REPORT;
      end
      ST_RSQ: begin
        ctl.sq_r  = 1'b1;
        state_nxt = ST_DIFF;
      end
      // Slots that fail the phase or box test are skipped without squaring.
      ST_DIFF: begin
        ctl.diff = 1'b1;
        if (sts.slot_ok) begin
          state_nxt = ST_SQX;
        end else if (sts.last) begin
          state_nxt = ST_REPORT;
        end else begin
          ctl.inc_idx = 1'b1;
        end
      end
      ST_SQX: begin
        ctl.sq_x  = 1'b1;
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        ctl.sq_y  = 1'b1;
        state_nxt = ST_CHECK;
      end
      // A hit ends the scan early.
      ST_CHECK: begin
        ctl.check = 1'b1;
        if (sts.slot_hit || sts.last) begin
          state_nxt = ST_REPORT;
        end else begin
          ctl.inc_idx = 1'b1;
          state_nxt   = ST_DIFF;
        end
      end
      ST_REPORT: begin
        ctl.report = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_REPORT);
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
